[src/masked_byte_pattern_finder_core_macros.svh]
// Assertion macros for the masked byte pattern finder core.
`ifndef MASKED_BYTE_PATTERN_FINDER_CORE_MACROS_SVH
`define MASKED_BYTE_PATTERN_FINDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define MBPF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge out of reset.
`define MBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MBPF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/mbpf_pkg.sv]
// Shared constants and types for the masked byte pattern finder.
package mbpf_pkg;

    localparam int BYTE_W            = 8;
    localparam int CFG_PATTERN_BYTES = 8;   // bytes held by the pattern and mask registers
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int BASE_FIELD_BITS   = 48;  // width of the base offset register field
    localparam int LEN_W             = 4;
    localparam int STEP_W            = 8;

    localparam int DEF_MAX_PATTERN_BYTES = 8;
    localparam int DEF_OFFSET_BITS       = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES   = 3'd0,
        REG_MASK_BYTES      = 3'd1,
        REG_PATTERN_LENGTH  = 3'd2,
        REG_STEP_SIZE       = 3'd3,
        REG_REVERSE_PATTERN = 3'd4,
        REG_BASE_OFFSET     = 3'd5
    } t_cfg_index;

endpackage

[src/masked_byte_pattern_finder_core.sv]
// Masked byte pattern finder: streaming search of one region for a masked byte pattern.
//
// Feed the bytes of a search region one beat at a time on the input channel, with
// i_last_byte set on the final byte. The core keeps a shift window of the newest
// bytes and checks it against the pattern (each byte ANDed with its mask byte) at
// every start position that is a multiple of step_size. The first match gives one
// result beat with found set and match_offset = base_offset + start position
// (saturating); the rest of that region gives nothing. A region that ends without a
// match gives one beat with found clear and a zero offset. Throughput is one byte
// per clock when not stalled: the window compare, phase check and offset add sit
// between the state registers and the output register, and the result appears in
// the cycle after the byte is taken. The output register lets a new byte in while
// a result waits, as long as the result is taken in the same cycle. Writing step_size
// starts a remainder pass (one quotient bit per cycle) that brings the running
// phase below the new step; input and configuration beats are held off during it.
// Write configuration only while the core is idle.
`include "masked_byte_pattern_finder_core_macros.svh"

module masked_byte_pattern_finder_core
    import mbpf_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // byte input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [BYTE_W-1:0]      i_data_byte,
    input  logic                   i_last_byte,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_found,
    output logic [OFFSET_BITS-1:0] o_match_offset
);

    localparam int WIN_W    = BYTE_W * MAX_PATTERN_BYTES;
    localparam int SRC_W    = $clog2(CFG_PATTERN_BYTES);
    localparam int LIM_BITS = (OFFSET_BITS < BASE_FIELD_BITS) ? OFFSET_BITS : BASE_FIELD_BITS;
    localparam logic [OFFSET_BITS-1:0] LIM_MASK = OFFSET_BITS'({LIM_BITS{1'b1}});
    localparam logic [LEN_W-1:0]       LEN_MAX  = LEN_W'(MAX_PATTERN_BYTES);

    // configuration registers
    logic [CFG_DATA_W-1:0]  r_pattern;
    logic [CFG_DATA_W-1:0]  r_mask;
    logic [LEN_W-1:0]       r_len;
    logic [STEP_W-1:0]      r_step;
    logic                   r_rev;
    logic [OFFSET_BITS-1:0] r_base;

    // region state
    logic [WIN_W-1:0]       r_window;
    logic [OFFSET_BITS-1:0] r_bytes_seen;
    logic [STEP_W-1:0]      r_start_phase;
    logic                   r_search_done;

    // remainder unit for step changes
    logic                   r_div_busy;
    logic [2:0]             r_div_cnt;
    logic [STEP_W-1:0]      r_div_num;
    logic [STEP_W-1:0]      r_div_rem;

    // output register
    logic                   r_out_valid;
    logic                   r_found;
    logic [OFFSET_BITS-1:0] r_match_offset;

    // combinational
    logic                   w_in_acc;
    logic                   w_cfg_acc;
    logic [LEN_W-1:0]       w_len;
    logic [LEN_W-1:0]       w_len_m1;
    logic [STEP_W-1:0]      w_step;
    logic [WIN_W-1:0]       n_window;
    logic                   w_window_full;
    logic [OFFSET_BITS-1:0] w_spos;
    logic [STEP_W-1:0]      w_start_phase;
    logic [BYTE_W-1:0]      w_pat_b [CFG_PATTERN_BYTES];
    logic [BYTE_W-1:0]      w_msk_b [CFG_PATTERN_BYTES];
    logic [SRC_W-1:0]       w_src [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] w_lane_ok;
    logic                   w_hit;
    logic                   w_has_result;
    logic [OFFSET_BITS:0]   w_sum;
    logic [OFFSET_BITS-1:0] w_offset;
    logic [OFFSET_BITS-1:0] n_bytes_seen;
    logic [STEP_W:0]        w_phase_inc;
    logic [STEP_W-1:0]      n_start_phase;
    logic [STEP_W:0]        w_div_shift;
    logic [STEP_W-1:0]      n_div_rem;

    assign o_cfg_ready = !r_div_busy;
    assign o_in_ready  = !r_div_busy && (!r_out_valid || i_out_ready);
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_match_offset;

    // effective length and step: zero acts as one, length clamps to the window
    assign w_len    = (r_len == '0) ? LEN_W'(1) : ((r_len > LEN_MAX) ? LEN_MAX : r_len);
    assign w_len_m1 = w_len - LEN_W'(1);
    assign w_step   = (r_step == '0) ? STEP_W'(1) : r_step;

    // shift the new byte in at the bottom; oldest byte drops off the top
    assign n_window = (r_window << BYTE_W) | WIN_W'(i_data_byte);

    assign w_window_full = r_bytes_seen >= OFFSET_BITS'(w_len_m1);
    assign w_spos        = r_bytes_seen - OFFSET_BITS'(w_len_m1);

    // walk the phase back from the newest byte to the window start
    always_comb begin
        w_start_phase = r_start_phase;
        for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
            if (LEN_W'(k) < w_len_m1) begin
                w_start_phase = (w_start_phase == '0) ? (w_step - STEP_W'(1))
                                                      : (w_start_phase - STEP_W'(1));
            end
        end
    end

    always_comb begin
        for (int b = 0; b < CFG_PATTERN_BYTES; b++) begin
            w_pat_b[b] = r_pattern[BYTE_W*b +: BYTE_W];
            w_msk_b[b] = r_mask[BYTE_W*b +: BYTE_W];
        end
    end

    // one lane per window byte; lane 0 holds the newest byte
    always_comb begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            w_src[j] = r_rev ? SRC_W'(j) : SRC_W'(w_len_m1 - LEN_W'(j));
            w_lane_ok[j] = (LEN_W'(j) > w_len_m1) ||
                ((n_window[BYTE_W*j +: BYTE_W] & w_msk_b[w_src[j]]) ==
                 (w_pat_b[w_src[j]] & w_msk_b[w_src[j]]));
        end
    end

    assign w_hit        = !r_search_done && w_window_full && (w_start_phase == '0) &&
                          (&w_lane_ok);
    assign w_has_result = !r_search_done && (w_hit || i_last_byte);

    // saturate the reported offset on carry out
    assign w_sum    = {1'b0, r_base} + {1'b0, w_spos};
    assign w_offset = (w_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : w_sum[OFFSET_BITS-1:0])
                      & LIM_MASK;

    assign n_bytes_seen  = (r_bytes_seen < LIM_MASK) ? (r_bytes_seen + OFFSET_BITS'(1))
                                                     : r_bytes_seen;
    assign w_phase_inc   = {1'b0, r_start_phase} + (STEP_W+1)'(1);
    assign n_start_phase = (w_phase_inc >= {1'b0, w_step}) ? '0 : w_phase_inc[STEP_W-1:0];

    // one restoring remainder step per cycle
    assign w_div_shift = {r_div_rem, r_div_num[STEP_W-1]};
    assign n_div_rem   = (w_div_shift >= {1'b0, w_step})
                         ? STEP_W'(w_div_shift - {1'b0, w_step})
                         : w_div_shift[STEP_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_mask    <= '1;
            r_len     <= LEN_W'(1);
            r_step    <= STEP_W'(1);
            r_rev     <= 1'b0;
            r_base    <= '0;
        end else if (w_cfg_acc) begin
            case (t_cfg_index'(i_cfg_index))
                REG_PATTERN_BYTES:   r_pattern <= i_cfg_data;
                REG_MASK_BYTES:      r_mask    <= i_cfg_data;
                REG_PATTERN_LENGTH:  r_len     <= i_cfg_data[LEN_W-1:0];
                REG_STEP_SIZE:       r_step    <= i_cfg_data[STEP_W-1:0];
                REG_REVERSE_PATTERN: r_rev     <= i_cfg_data[0];
                REG_BASE_OFFSET:     r_base    <= i_cfg_data[OFFSET_BITS-1:0] & LIM_MASK;
                default: ;
            endcase
        end
    end

    // region state and remainder pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen  <= '0;
            r_start_phase <= '0;
            r_search_done <= 1'b0;
            r_div_busy    <= 1'b0;
            r_div_cnt     <= '0;
        end else if (r_div_busy) begin
            r_div_rem <= n_div_rem;
            r_div_num <= r_div_num << 1;
            r_div_cnt <= r_div_cnt - 3'd1;
            if (r_div_cnt == '0) begin
                r_start_phase <= n_div_rem;
                r_div_busy    <= 1'b0;
            end
        end else if (w_cfg_acc && (t_cfg_index'(i_cfg_index) == REG_STEP_SIZE)) begin
            // start reducing the phase against the new step
            r_div_busy <= 1'b1;
            r_div_cnt  <= 3'd7;
            r_div_num  <= r_start_phase;
            r_div_rem  <= '0;
        end else if (w_in_acc) begin
            if (i_last_byte) begin
                r_bytes_seen  <= '0;
                r_start_phase <= '0;
                r_search_done <= 1'b0;
            end else if (!r_search_done) begin
                r_bytes_seen  <= n_bytes_seen;
                r_start_phase <= n_start_phase;
                r_search_done <= w_hit;
            end
        end
    end

    // window holds no reset: a compare only looks at bytes of the current region
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !r_search_done) begin
            r_window <= n_window;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= w_has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_has_result) begin
            r_found        <= w_hit;
            r_match_offset <= w_hit ? w_offset : '0;
        end
    end

    // a not-found beat always carries a zero offset
    `MBPF_ASSERT_IMPLIES(a_notfound_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_match_offset == '0)
    // the end of a region clears the count and the done flag
    `MBPF_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_in_acc && i_last_byte, (r_bytes_seen == '0) && !r_search_done)
    // once matched, the rest of the region gives no result
    `MBPF_ASSERT_NEXT(a_done_silent, i_clk, i_rst_n, w_in_acc && r_search_done, !o_out_valid)
    // outside the remainder pass the phase stays below the step
    `MBPF_ASSERT_IMPLIES(a_phase_below_step, i_clk, i_rst_n, !r_div_busy, r_start_phase < w_step)

endmodule
